/* sv/svd_pkg.sv */
// Shared types and constants for the sparse vertex delta run encoder.
`timescale 1ns / 1ps
package svd_pkg;

	localparam int COORD_W     = 32;
	localparam int DELTA_W     = 33;
	localparam int RUN_W       = 16;
	localparam int INDEX_BITS  = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic KIND_DELTA = 1'b0;
	localparam logic KIND_RUN   = 1'b1;

	// One queued item: what the front decided, the back still has to emit.
	typedef struct packed {
		logic                      has_delta;
		logic                      has_run;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic signed [DELTA_W-1:0] dz;
		logic        [RUN_W-1:0]   run_begin;
		logic        [RUN_W-1:0]   run_count;
		logic                      ovf;
	} entry_t;

endpackage

/* sv/svd_vertex_if.sv */
// Vertex pair channel: valid/ready handshake with original and target positions.
`timescale 1ns / 1ps
interface svd_vertex_if;
	logic                                valid;
	logic                                ready;
	logic signed [svd_pkg::COORD_W-1:0] orig_x;
	logic signed [svd_pkg::COORD_W-1:0] orig_y;
	logic signed [svd_pkg::COORD_W-1:0] orig_z;
	logic signed [svd_pkg::COORD_W-1:0] target_x;
	logic signed [svd_pkg::COORD_W-1:0] target_y;
	logic signed [svd_pkg::COORD_W-1:0] target_z;
	logic                                final_vertex;

	modport source (output valid, orig_x, orig_y, orig_z, target_x, target_y, target_z,
		final_vertex, input ready);
	modport sink (input valid, orig_x, orig_y, orig_z, target_x, target_y, target_z,
		final_vertex, output ready);
endinterface

/* sv/svd_record_if.sv */
// Record channel: valid/ready handshake carrying delta and run records.
`timescale 1ns / 1ps
interface svd_record_if;
	logic                                valid;
	logic                                ready;
	logic                                record_kind;
	logic signed [svd_pkg::DELTA_W-1:0] delta_x;
	logic signed [svd_pkg::DELTA_W-1:0] delta_y;
	logic signed [svd_pkg::DELTA_W-1:0] delta_z;
	logic        [svd_pkg::RUN_W-1:0]   run_begin;
	logic        [svd_pkg::RUN_W-1:0]   run_count;
	logic                                index_overflow;
	logic                                last_of_item;

	modport source (output valid, record_kind, delta_x, delta_y, delta_z, run_begin,
		run_count, index_overflow, last_of_item, input ready);
	modport sink (input valid, record_kind, delta_x, delta_y, delta_z, run_begin,
		run_count, index_overflow, last_of_item, output ready);
endinterface

/* sv/sparse_vertex_delta_run_encoder.sv */
// Top level of the sparse vertex delta run encoder.
`timescale 1ns / 1ps
// Usage:
//   vertex : sink channel, one original/target vertex pair per item plus
//            final_vertex marking the last vertex of a mesh.
//   result : source channel, delta records (kind 0) and run records (kind 1);
//            last_of_item flags the final record caused by one vertex.
// A changed vertex gives a delta record; an equal vertex closing an open run
// gives a run record; a changed last vertex gives both, delta first. An equal
// vertex with no open run gives nothing.
// Throughput: one vertex per cycle while the queue is not full, set by the front
// end's combinational compare/subtract and run update. The back end emits one
// record per cycle while result.ready allows; a vertex that yields two records
// stays at the queue head until its second record is loaded.
// Path: an accepted vertex is written into the queue, then its first record is
// loaded from the queue head into the output register.
// Stall: when result.ready is low with a record valid, the output register holds; the
// queue of QUEUE_DEPTH items absorbs input until full, then vertex.ready drops.
// Reset: arst_n clears the index, run state, overflow flag, queue and output
// valid; the first vertex after reset is index zero.
module sparse_vertex_delta_run_encoder #(
	parameter int INDEX_BITS  = svd_pkg::INDEX_BITS,
	parameter int QUEUE_DEPTH = svd_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	svd_vertex_if.sink   vertex,
	svd_record_if.source result
);
	// front -> queue
	logic            push;
	svd_pkg::entry_t wr_entry;
	logic            full;

	// queue -> back
	svd_pkg::entry_t head;
	logic            empty;
	logic            pop;

	svd_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.vertex(vertex),
		.full  (full),
		.push  (push),
		.entry (wr_entry)
	);

	svd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	svd_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);
endmodule

/* sv/svd_front.sv */
// Front end: takes vertex pairs, computes deltas and keeps the run bookkeeping.
`timescale 1ns / 1ps
module svd_front #(
	parameter int INDEX_BITS = svd_pkg::INDEX_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	svd_vertex_if.sink      vertex,
	input  logic            full,
	output logic            push,
	output svd_pkg::entry_t entry
);
	localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS-1:0] start_q;
	logic                  run_open_q;
	logic                  ovf_q;

	logic                  accept;
	logic                  changed;
	logic                  ovf;
	logic                  has_run;
	logic [INDEX_BITS-1:0] start_eff;
	logic [INDEX_BITS:0]   span;
	logic [INDEX_BITS:0]   cnt_raw;
	logic [INDEX_BITS-1:0] cnt_sat;

	assign vertex.ready = !full;
	assign accept       = vertex.valid && vertex.ready;

	assign changed = (vertex.orig_x != vertex.target_x) || (vertex.orig_y != vertex.target_y)
		|| (vertex.orig_z != vertex.target_z);
	assign ovf     = ovf_q || (idx_q == IDX_MAX);

	// a run opened by this very vertex starts here
	assign start_eff = run_open_q ? start_q : idx_q;
	assign span      = {1'b0, idx_q} - {1'b0, start_eff};
	assign cnt_raw   = (changed && vertex.final_vertex) ? span + 1'b1 : span;
	assign cnt_sat   = cnt_raw[INDEX_BITS] ? IDX_MAX : cnt_raw[INDEX_BITS-1:0];

	assign has_run = changed ? vertex.final_vertex : run_open_q;
	assign push    = accept && (changed || has_run);

	always_comb begin
		entry           = '0;
		entry.has_delta = changed;
		entry.has_run   = has_run;
		entry.dx        = {vertex.target_x[svd_pkg::COORD_W-1], vertex.target_x}
			- {vertex.orig_x[svd_pkg::COORD_W-1], vertex.orig_x};
		entry.dy        = {vertex.target_y[svd_pkg::COORD_W-1], vertex.target_y}
			- {vertex.orig_y[svd_pkg::COORD_W-1], vertex.orig_y};
		entry.dz        = {vertex.target_z[svd_pkg::COORD_W-1], vertex.target_z}
			- {vertex.orig_z[svd_pkg::COORD_W-1], vertex.orig_z};
		entry.run_begin = svd_pkg::RUN_W'(start_eff);
		entry.run_count = svd_pkg::RUN_W'(cnt_sat);
		entry.ovf       = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			start_q    <= '0;
			run_open_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (vertex.final_vertex) begin
				idx_q      <= '0;
				start_q    <= '0;
				run_open_q <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				ovf_q <= ovf;
				if (idx_q != IDX_MAX)
					idx_q <= idx_q + 1'b1;
				if (changed && !run_open_q) begin
					run_open_q <= 1'b1;
					start_q    <= idx_q;
				end else if (!changed) begin
					run_open_q <= 1'b0;
				end
			end
		end
	end

	a_start_le_idx: assert property (@(posedge clk) disable iff (!arst_n)
		run_open_q |-> (start_q <= idx_q))
		else $error("open run starts past the current index");
	a_ovf_pinned: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (idx_q == IDX_MAX))
		else $error("overflow seen while index not saturated");
endmodule

/* sv/svd_queue.sv */
// Short register queue between front and back end.
`timescale 1ns / 1ps
module svd_queue #(
	parameter int DEPTH = svd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  svd_pkg::entry_t wr_entry,
	input  logic            pop,
	output svd_pkg::entry_t head,
	output logic            full,
	output logic            empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	svd_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
endmodule

/* sv/svd_back.sv */
// Back end: expands queued items into delta and run records on the output register.
`timescale 1ns / 1ps
module svd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  svd_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	svd_record_if.source    result
);
	logic valid_q;
	logic delta_done_q;
	logic load;
	logic emit_delta;

	assign load       = !valid_q || result.ready;
	assign emit_delta = head.has_delta && !delta_done_q;
	// the head leaves once its final record goes to the output register
	assign pop        = load && !empty && !(emit_delta && head.has_run);

	assign result.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			delta_done_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty)
				delta_done_q <= emit_delta && head.has_run;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			result.index_overflow <= head.ovf;
			if (emit_delta) begin
				result.record_kind  <= svd_pkg::KIND_DELTA;
				result.delta_x      <= head.dx;
				result.delta_y      <= head.dy;
				result.delta_z      <= head.dz;
				result.run_begin    <= '0;
				result.run_count    <= '0;
				result.last_of_item <= !head.has_run;
			end else begin
				result.record_kind  <= svd_pkg::KIND_RUN;
				result.delta_x      <= '0;
				result.delta_y      <= '0;
				result.delta_z      <= '0;
				result.run_begin    <= head.run_begin;
				result.run_count    <= head.run_count;
				result.last_of_item <= 1'b1;
			end
		end
	end

	a_split_pending: assert property (@(posedge clk) disable iff (!arst_n)
		delta_done_q |-> (!empty && head.has_run))
		else $error("second half pending without a run at the queue head");
	a_run_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && result.record_kind == svd_pkg::KIND_RUN) |-> result.last_of_item)
		else $error("run record not flagged last of item");
endmodule
